// ===== rtl/core/spr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants
// Command/status groups, state encoding and field widths of the resampler.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int DATA_W      = 24;
    localparam int IDX_W       = 8;
    localparam int SUM_W       = 33;
    localparam int RATE_W      = 16;
    localparam int ACC_W       = 25;
    localparam int CNT_W       = 8;
    localparam int STORE_DEPTH = 256;
    localparam int N_W         = 9;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIRST,
        ST_FETCH,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load_we;
        logic draw_start;
        logic div_step;
        logic first_sum;
        logic scan;
        logic rd_zero;
    } cmd_t;

    typedef struct packed {
        logic first_draw;
        logic advance;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/systematic_particle_resampler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// systematic_particle_resampler: systematic resampler top level
// Load beats give no result. A draw beat holds busy through the weight fetch
// and the scan, with one cursor advance per cycle over the weight store read
// port, and also through the offset scaling multiply on the first draw of a
// pass. done marks the result beat in the first cycle with busy low; results
// cannot be stalled. Reset clears cursor, sum, draw count, offset and rate;
// weights are undefined until loaded.
// ----------------------------------------------------------------------------
module systematic_particle_resampler
#(
    parameter int PARTICLE_COUNT = 256
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        action,
    input  wire logic [spr_pkg::IDX_W-1:0]   weight_index,
    input  wire logic [spr_pkg::DATA_W-1:0]  weight_value,
    input  wire logic [spr_pkg::DATA_W-1:0]  start_offset,
    input  wire logic [spr_pkg::RATE_W-1:0]  inject_draw,
    input  wire logic                        injection_rate_we,
    input  wire logic [spr_pkg::RATE_W-1:0]  injection_rate_wdata,
    output logic                             done,
    output logic [spr_pkg::IDX_W-1:0]        source_index,
    output logic                             inject,
    output logic                             last
);

    localparam int EFF_N = (PARTICLE_COUNT > spr_pkg::STORE_DEPTH) ? spr_pkg::STORE_DEPTH
                         : ((PARTICLE_COUNT < 1) ? 1 : PARTICLE_COUNT);

    spr_pkg::cmd_t    cmd;
    spr_pkg::status_t status;

    spr_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    spr_dp #(.EFF_N(EFF_N)) u_dp
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .weight_index         (weight_index),
        .weight_value         (weight_value),
        .start_offset         (start_offset),
        .inject_draw          (inject_draw),
        .injection_rate_we    (injection_rate_we),
        .injection_rate_wdata (injection_rate_wdata),
        .done                 (done),
        .source_index         (source_index),
        .inject               (inject),
        .last                 (last)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a draw in progress");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == spr_pkg::ACT_LOAD) |=> !done)
        else $error("load beat produced a result");

    a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("draw finished without a result beat");

endmodule
`default_nettype wire

// ===== rtl/core/spr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spr_ctrl: resampler controller
// Sequences load beats, the offset scaling, the weight fetch and the scan.
// ----------------------------------------------------------------------------
module spr_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             action,
    input  wire spr_pkg::status_t status,
    output spr_pkg::cmd_t         cmd,
    output logic                  busy
);

    spr_pkg::state_t state_reg;
    spr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            spr_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (action == spr_pkg::ACT_LOAD)
                    begin
                        cmd.load_we = 1'b1;
                    end
                    else
                    begin
                        cmd.draw_start = 1'b1;
                        state_next     = status.first_draw ? spr_pkg::ST_DIV
                                                           : spr_pkg::ST_FETCH;
                    end
                end
            end
            spr_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.rd_zero  = 1'b1;
                state_next   = spr_pkg::ST_FIRST;
            end
            spr_pkg::ST_FIRST:
            begin
                cmd.first_sum = 1'b1;
                state_next    = spr_pkg::ST_SCAN;
            end
            spr_pkg::ST_FETCH:
            begin
                state_next = spr_pkg::ST_SCAN;
            end
            spr_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (!status.advance)
                begin
                    state_next = spr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/spr_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spr_dp: resampler datapath
// Weight store, reciprocal offset scaler, draw position accumulator,
// cursor and running sum, registered result beat.
// ----------------------------------------------------------------------------
module spr_dp
#(
    parameter int EFF_N = 256
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire spr_pkg::cmd_t               cmd,
    output spr_pkg::status_t                 status,
    input  wire logic [spr_pkg::IDX_W-1:0]   weight_index,
    input  wire logic [spr_pkg::DATA_W-1:0]  weight_value,
    input  wire logic [spr_pkg::DATA_W-1:0]  start_offset,
    input  wire logic [spr_pkg::RATE_W-1:0]  inject_draw,
    input  wire logic                        injection_rate_we,
    input  wire logic [spr_pkg::RATE_W-1:0]  injection_rate_wdata,
    output logic                             done,
    output logic [spr_pkg::IDX_W-1:0]        source_index,
    output logic                             inject,
    output logic                             last
);

    localparam int STEP = (1 << spr_pkg::DATA_W) / EFF_N;
    localparam int REM  = (1 << spr_pkg::DATA_W) % EFF_N;
    localparam int SCALE_SH = spr_pkg::DATA_W + $clog2(EFF_N);
    localparam longint RECIP = ((longint'(1) << SCALE_SH) + longint'(EFF_N) - 1)
                               / longint'(EFF_N);
    localparam int PROD_W = spr_pkg::DATA_W + spr_pkg::ACC_W;
    localparam logic [spr_pkg::ACC_W-1:0] RECIP_VAL = spr_pkg::ACC_W'(RECIP);
    localparam logic [spr_pkg::N_W-1:0]   N_VAL     = spr_pkg::N_W'(EFF_N);
    localparam logic [spr_pkg::IDX_W-1:0] LAST_IDX  = spr_pkg::IDX_W'(EFF_N - 1);
    localparam logic [spr_pkg::CNT_W-1:0] LAST_DRAW = spr_pkg::CNT_W'(EFF_N - 1);

    logic [spr_pkg::DATA_W-1:0] mem [spr_pkg::STORE_DEPTH];
    logic [spr_pkg::DATA_W-1:0] rdata_reg;
    logic [spr_pkg::IDX_W-1:0]  rd_addr;

    logic [spr_pkg::RATE_W-1:0] inj_rate_reg, inj_rate_next;
    logic [spr_pkg::IDX_W-1:0]  cursor_reg, cursor_next;
    logic [spr_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [spr_pkg::CNT_W-1:0]  draw_cnt_reg, draw_cnt_next;
    logic [spr_pkg::DATA_W-1:0] base_reg, base_next;
    logic [spr_pkg::ACC_W-1:0]  q_reg, q_next;
    logic [spr_pkg::IDX_W-1:0]  qr_reg, qr_next;
    logic [spr_pkg::ACC_W-1:0]  u_reg, u_next;
    logic [spr_pkg::DATA_W-1:0] dq_reg, dq_next;
    logic                       inj_reg, inj_next;
    logic                       done_reg, done_next;
    logic [spr_pkg::IDX_W-1:0]  src_reg, src_next;
    logic                       inj_out_reg, inj_out_next;
    logic                       last_reg, last_next;

    logic                       advance;
    logic                       emit;
    logic                       is_last;
    logic [PROD_W-1:0]          scaled_off;
    logic [spr_pkg::N_W-1:0]    qr_sum;
    logic                       carry;

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            mem[weight_index] <= weight_value;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        advance = ({{(spr_pkg::SUM_W - spr_pkg::ACC_W){1'b0}}, u_reg} > sum_reg)
                  && (cursor_reg < LAST_IDX);
        emit    = cmd.scan && !advance;
        is_last = (draw_cnt_reg >= LAST_DRAW);
        status.first_draw = (draw_cnt_reg == '0);
        status.advance    = advance;

        if (cmd.rd_zero)
            rd_addr = '0;
        else if (cmd.scan && advance)
            rd_addr = cursor_reg + spr_pkg::IDX_W'(2);
        else
            rd_addr = cursor_reg + spr_pkg::IDX_W'(1);

        scaled_off = {{spr_pkg::ACC_W{1'b0}}, dq_reg}
                     * {{spr_pkg::DATA_W{1'b0}}, RECIP_VAL};
        qr_sum     = {1'b0, qr_reg} + spr_pkg::N_W'(REM);
        carry      = (qr_sum >= N_VAL);

        inj_rate_next = injection_rate_we ? injection_rate_wdata : inj_rate_reg;
        cursor_next   = cursor_reg;
        sum_next      = sum_reg;
        draw_cnt_next = draw_cnt_reg;
        base_next     = base_reg;
        q_next        = q_reg;
        qr_next       = qr_reg;
        u_next        = u_reg;
        dq_next       = dq_reg;
        inj_next      = inj_reg;
        done_next     = 1'b0;
        src_next      = src_reg;
        inj_out_next  = inj_out_reg;
        last_next     = last_reg;

        if (cmd.draw_start)
        begin
            inj_next = (inject_draw < inj_rate_reg);
            if (status.first_draw)
            begin
                dq_next     = start_offset;
                cursor_next = '0;
                q_next      = '0;
                qr_next     = '0;
            end
            else
            begin
                u_next = {1'b0, base_reg} + q_reg;
            end
        end

        if (cmd.div_step)
        begin
            dq_next = spr_pkg::DATA_W'(scaled_off >> SCALE_SH);
        end

        if (cmd.first_sum)
        begin
            base_next = dq_reg;
            u_next    = {1'b0, dq_reg};
            sum_next  = {{(spr_pkg::SUM_W - spr_pkg::DATA_W){1'b0}}, rdata_reg};
        end

        if (cmd.scan && advance)
        begin
            cursor_next = cursor_reg + 1'b1;
            sum_next    = sum_reg
                          + {{(spr_pkg::SUM_W - spr_pkg::DATA_W){1'b0}}, rdata_reg};
        end

        if (emit)
        begin
            done_next     = 1'b1;
            src_next      = cursor_reg;
            inj_out_next  = inj_reg;
            last_next     = is_last;
            draw_cnt_next = is_last ? '0 : draw_cnt_reg + 1'b1;
            qr_next       = carry ? spr_pkg::IDX_W'(qr_sum - N_VAL)
                                  : qr_sum[spr_pkg::IDX_W-1:0];
            q_next        = q_reg + spr_pkg::ACC_W'(STEP)
                            + {{(spr_pkg::ACC_W - 1){1'b0}}, carry};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inj_rate_reg <= '0;
            cursor_reg   <= '0;
            sum_reg      <= '0;
            draw_cnt_reg <= '0;
            base_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            inj_rate_reg <= inj_rate_next;
            cursor_reg   <= cursor_next;
            sum_reg      <= sum_next;
            draw_cnt_reg <= draw_cnt_next;
            base_reg     <= base_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        qr_reg      <= qr_next;
        u_reg       <= u_next;
        dq_reg      <= dq_next;
        inj_reg     <= inj_next;
        src_reg     <= src_next;
        inj_out_reg <= inj_out_next;
        last_reg    <= last_next;
    end

    assign done         = done_reg;
    assign source_index = src_reg;
    assign inject       = inj_out_reg;
    assign last         = last_reg;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: systematic particle resampler testbench
// Fills the weight store, then sends directed beats (weight extremes, surplus
// weight, injection at both rate extremes, loads in the middle of a pass) and
// then random passes over normalized, spiky and unnormalized weight sets, with
// random start gaps in most phases. A cycle-free predictor tracks cursor,
// running sum, draw count and offset; every draw result is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int PARTICLE_COUNT = 256;
    localparam int EFF_N = (PARTICLE_COUNT > spr_pkg::STORE_DEPTH) ? spr_pkg::STORE_DEPTH
                         : PARTICLE_COUNT;
    localparam int ITEM_TARGET = 1500;
    localparam int QUIET_TAIL = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [spr_pkg::RATE_W-1:0] RATE_MAX = '1;
    localparam logic [spr_pkg::DATA_W-1:0] WEIGHT_MAX = '1;
    localparam logic [spr_pkg::DATA_W-1:0] WEIGHT_ONE_256 = spr_pkg::DATA_W'(1 << 16);

    typedef struct packed {
        logic [spr_pkg::IDX_W-1:0] source_index;
        logic                      inject;
        logic                      last;
    } draw_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         action;
    logic [spr_pkg::IDX_W-1:0]    weight_index;
    logic [spr_pkg::DATA_W-1:0]   weight_value;
    logic [spr_pkg::DATA_W-1:0]   start_offset;
    logic [spr_pkg::RATE_W-1:0]   inject_draw;
    logic                         injection_rate_we;
    logic [spr_pkg::RATE_W-1:0]   injection_rate_wdata;
    logic                         done;
    logic [spr_pkg::IDX_W-1:0]    source_index;
    logic                         inject;
    logic                         last;

    systematic_particle_resampler #(
        .PARTICLE_COUNT(PARTICLE_COUNT)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .action               (action),
        .weight_index         (weight_index),
        .weight_value         (weight_value),
        .start_offset         (start_offset),
        .inject_draw          (inject_draw),
        .injection_rate_we    (injection_rate_we),
        .injection_rate_wdata (injection_rate_wdata),
        .done                 (done),
        .source_index         (source_index),
        .inject               (inject),
        .last                 (last)
    );

    // predictor state
    logic [spr_pkg::DATA_W-1:0] weight_mem [spr_pkg::STORE_DEPTH];
    logic [spr_pkg::IDX_W-1:0]  pick_cursor;
    logic [spr_pkg::SUM_W-1:0]  cum_weight;
    logic [spr_pkg::CNT_W-1:0]  draw_num;
    logic [spr_pkg::DATA_W-1:0] base_u;
    logic [spr_pkg::RATE_W-1:0] rate_q;

    draw_result_t expected_draws[$];
    int           error_count;
    int           item_count;
    int           stall_cycles;
    bit           gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic draw_result_t resample_draw(logic [spr_pkg::DATA_W-1:0] offs,
                                                   logic [spr_pkg::RATE_W-1:0] idraw);
        logic [63:0]  u;
        draw_result_t r;
        if (draw_num == '0)
        begin
            base_u = spr_pkg::DATA_W'(32'(offs) / EFF_N);
            pick_cursor = '0;
            cum_weight = spr_pkg::SUM_W'(weight_mem[0]);
        end
        u = 64'(base_u) + ((64'(draw_num) << 24) / EFF_N);
        while (u > 64'(cum_weight) && int'(pick_cursor) < EFF_N - 1)
        begin
            pick_cursor = pick_cursor + 1'b1;
            cum_weight = cum_weight + spr_pkg::SUM_W'(weight_mem[pick_cursor]);
        end
        r.source_index = pick_cursor;
        r.inject = (idraw < rate_q);
        r.last = (int'(draw_num) >= EFF_N - 1);
        draw_num = r.last ? '0 : draw_num + 1'b1;
        return r;
    endfunction

    task automatic send_item(logic act, logic [spr_pkg::IDX_W-1:0] idx,
                             logic [spr_pkg::DATA_W-1:0] wval,
                             logic [spr_pkg::DATA_W-1:0] offs,
                             logic [spr_pkg::RATE_W-1:0] idraw);
        int gap;
        if (gaps_on && item_count < ITEM_TARGET - QUIET_TAIL && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            repeat (gap)
            begin
                @(negedge clk);
                start = 1'b0;
            end
        end
        @(negedge clk);
        start = 1'b1;
        action = act;
        weight_index = idx;
        weight_value = wval;
        start_offset = offs;
        inject_draw = idraw;
        do
            @(posedge clk);
        while (busy);
        item_count++;
        if (act == spr_pkg::ACT_LOAD)
            weight_mem[idx] = wval;
        else
            expected_draws.insert(expected_draws.size(), resample_draw(offs, idraw));
    endtask

    task automatic load_weight(logic [spr_pkg::IDX_W-1:0] idx,
                               logic [spr_pkg::DATA_W-1:0] wval);
        send_item(spr_pkg::ACT_LOAD, idx, wval, spr_pkg::DATA_W'($urandom),
                  spr_pkg::RATE_W'($urandom));
    endtask

    task automatic draw(logic [spr_pkg::DATA_W-1:0] offs, logic [spr_pkg::RATE_W-1:0] idraw);
        send_item(spr_pkg::ACT_DRAW, spr_pkg::IDX_W'($urandom), spr_pkg::DATA_W'($urandom),
                  offs, idraw);
    endtask

    // wait until no result is outstanding and a trailing load has retired
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (expected_draws.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_injection_rate(logic [spr_pkg::RATE_W-1:0] value);
        settle();
        @(negedge clk);
        injection_rate_we = 1'b1;
        injection_rate_wdata = value;
        @(negedge clk);
        injection_rate_we = 1'b0;
        injection_rate_wdata = spr_pkg::RATE_W'($urandom);
        rate_q = value;
    endtask

    task automatic load_weight_set(int mode);
        logic [31:0] raw [spr_pkg::STORE_DEPTH];
        int          order [spr_pkg::STORE_DEPTH];
        longint      total;
        longint      target;
        longint      scaled;
        int          j;
        int          tmp;
        total = 0;
        for (int i = 0; i < spr_pkg::STORE_DEPTH; i++)
        begin
            case (mode)
                0: raw[i] = $urandom_range(0, 65535);
                1: raw[i] = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 1 << 20) : 0;
                default: raw[i] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1000);
            endcase
            total += raw[i];
            order[i] = i;
        end
        if (total == 0)
        begin
            raw[0] = 1;
            total = 1;
        end
        // mode 3 leaves the set off one: short or surplus total weight
        target = (mode == 3) ? longint'($urandom_range(1 << 22, 1 << 25)) : (longint'(1) << 24);
        for (int i = spr_pkg::STORE_DEPTH - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < spr_pkg::STORE_DEPTH; i++)
        begin
            scaled = longint'(raw[order[i]]) * target / total;
            if (scaled > longint'(WEIGHT_MAX))
                scaled = longint'(WEIGHT_MAX);
            load_weight(spr_pkg::IDX_W'(order[i]), spr_pkg::DATA_W'(scaled));
        end
    endtask

    // draws to the end of the current pass, with stray loads mixed in when noisy is set
    task automatic finish_pass(bit noisy);
        do
        begin
            if (noisy && $urandom_range(0, 31) == 0)
                load_weight(spr_pkg::IDX_W'($urandom), spr_pkg::DATA_W'($urandom));
            draw(spr_pkg::DATA_W'($urandom), spr_pkg::RATE_W'($urandom));
        end
        while (draw_num != '0);
    endtask

    task automatic test_fill_store();
        set_injection_rate('0);
        for (int i = 0; i < spr_pkg::STORE_DEPTH; i++)
            load_weight(spr_pkg::IDX_W'(i), WEIGHT_ONE_256);
    endtask

    task automatic test_weight_extremes();
        load_weight('0, '0);
        load_weight(spr_pkg::IDX_W'(1), WEIGHT_MAX);
        draw(WEIGHT_MAX, RATE_MAX);
        draw('0, '0);
    endtask

    task automatic test_injection();
        set_injection_rate(RATE_MAX);
        draw(spr_pkg::DATA_W'($urandom), '0);
        draw(spr_pkg::DATA_W'($urandom), RATE_MAX - 1'b1);
        draw(spr_pkg::DATA_W'($urandom), RATE_MAX);
        set_injection_rate(spr_pkg::RATE_W'(1));
        draw(spr_pkg::DATA_W'($urandom), '0);
        draw(spr_pkg::DATA_W'($urandom), spr_pkg::RATE_W'(1));
    endtask

    task automatic test_load_during_pass();
        load_weight(spr_pkg::IDX_W'(1), '0);
        load_weight(spr_pkg::IDX_W'(2), spr_pkg::DATA_W'(24'h800000));
        draw(spr_pkg::DATA_W'($urandom), spr_pkg::RATE_W'($urandom));
        draw(spr_pkg::DATA_W'($urandom), spr_pkg::RATE_W'($urandom));
        load_weight(spr_pkg::IDX_W'(spr_pkg::STORE_DEPTH - 1), WEIGHT_MAX);
        draw(spr_pkg::DATA_W'($urandom), spr_pkg::RATE_W'($urandom));
    endtask

    task automatic test_random_passes();
        int phase;
        int mode;
        phase = 0;
        while (item_count < ITEM_TARGET)
        begin
            case (phase % 4)
                0: set_injection_rate('0);
                1: set_injection_rate(RATE_MAX);
                default: set_injection_rate(spr_pkg::RATE_W'($urandom));
            endcase
            gaps_on = (item_count < ITEM_TARGET - QUIET_TAIL) && (phase % 3 != 2);
            mode = $urandom_range(0, 4);
            if (mode == 4)
            begin
                repeat (24)
                    load_weight(spr_pkg::IDX_W'($urandom),
                                spr_pkg::DATA_W'($urandom_range(0, 1 << 17)));
            end
            else
                load_weight_set(mode);
            finish_pass(1'b1);
            phase++;
        end
        gaps_on = 1'b0;
    endtask

    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n && done !== 1'b0)
        begin
            if (expected_draws.size() == 0)
            begin
                $error("unexpected result beat: source_index %0d", source_index);
                error_count++;
            end
            else
            begin
                want = expected_draws.pop_front();
                if (source_index !== want.source_index)
                begin
                    $error("source_index: expected %0d, actual %0d",
                           want.source_index, source_index);
                    error_count++;
                end
                if (inject !== want.inject)
                begin
                    $error("inject: expected %0d, actual %0d", want.inject, inject);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = spr_pkg::ACT_LOAD;
        weight_index = '0;
        weight_value = '0;
        start_offset = '0;
        inject_draw = '0;
        injection_rate_we = 1'b0;
        injection_rate_wdata = '0;
        pick_cursor = '0;
        cum_weight = '0;
        draw_num = '0;
        base_u = '0;
        rate_q = '0;
        error_count = 0;
        item_count = 0;
        stall_cycles = 0;
        gaps_on = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_fill_store();
        test_weight_extremes();
        test_injection();
        test_load_during_pass();
        test_random_passes();

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_draws.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
